/* rtl/core/lirs_pkg.sv */
`default_nettype none

package lirs_pkg;

    // fixed formats of the channel and configuration fields
    localparam int MAX_CHANNELS = 4;
    localparam int FRAC_BITS    = 16;
    localparam int SAMPLE_W     = 16;
    localparam int STEP_W       = 20;
    localparam int CCNT_W       = 3;
    localparam int SFRAC_W      = 16;
    localparam int PHASE_W      = 20;
    localparam int POS_W        = PHASE_W + 1;
    localparam int MAX_RESULTS  = 64;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;

    // lane arithmetic widths
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RND_W  = ACC_W - FRAC_BITS;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRACTION = 2'd2;

    // one source frame in position units
    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;

    // saturation bounds
    localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(32768);
    localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(32767);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

    // one output position handed to the lanes
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [FRAC_BITS-1:0] frac;
    } issue_t;

endpackage

`default_nettype wire

/* rtl/core/lirs_lane.sv */
`default_nettype none

module lirs_lane
    import lirs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire issue_t              issue,
    input  wire logic                use_ch,
    input  wire logic [SAMPLE_W-1:0] prev_s,
    input  wire logic [SAMPLE_W-1:0] cur_s,
    output logic      [SAMPLE_W-1:0] res
);

    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic        [SAMPLE_W-1:0] base_reg;
    logic                       use_reg;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [RND_W-1:0]    q;

    // slope times fraction
    assign diff      = $signed({cur_s[SAMPLE_W-1], cur_s}) - $signed({prev_s[SAMPLE_W-1], prev_s});
    assign prod_next = $signed({1'b0, issue.frac}) * diff;

    always_ff @(posedge clk)
    begin
        if (en && issue.valid)
        begin
            prod_reg <= prod_next;
            base_reg <= prev_s;
            use_reg  <= use_ch;
        end
    end

    // add base, round half away from zero
    always_comb
    begin
        acc = ($signed(ACC_W'($signed(base_reg))) <<< FRAC_BITS)
              + $signed(ACC_W'(prod_reg));
        if (acc[ACC_W-1])
            acc_rnd = acc + $signed(ACC_W'((1 << (FRAC_BITS - 1)) - 1));
        else
            acc_rnd = acc + $signed(ACC_W'(1 << (FRAC_BITS - 1)));
        q = RND_W'(acc_rnd >>> FRAC_BITS);
    end

    // saturate, zero for unused channels
    always_comb
    begin
        if (!use_reg)
            res = '0;
        else if (q < SAT_MIN)
            res = SAT_MIN[SAMPLE_W-1:0];
        else if (q > SAT_MAX)
            res = SAT_MAX[SAMPLE_W-1:0];
        else
            res = q[SAMPLE_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/core/lirs_merge.sv */
`default_nettype none

module lirs_merge
    import lirs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire issue_t issue,
    input  wire frame_t lane_res,
    input  wire logic   out_stall,
    output logic        en,
    output logic        out_valid,
    output frame_t      out_frame,
    output logic        out_last
);

    logic   s1_valid_reg;
    logic   s1_last_reg;
    logic   out_valid_reg;
    logic   out_last_reg;
    frame_t out_frame_reg;

    // pipeline advances whenever the output register can take a transaction
    assign en = !out_valid_reg || !out_stall;

    // control alongside the lane multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= issue.valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // gather lane results into one output transaction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_last_reg <= issue.last;
            if (s1_valid_reg)
            begin
                out_frame_reg <= lane_res;
                out_last_reg  <= s1_last_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_frame = out_frame_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/linear_interp_speed_resampler_unit.sv */
`default_nettype none

// Linear interpolation speed resampler.
// Input channel: one source frame per transaction (sample_ch0..3, end_of_stream),
// taken when in_valid is high and in_stall is low. in_stall stays high while the
// sequencer walks the output positions of the frame just taken.
// Output channel: one interpolated frame per transaction (out_ch0..3), with
// last_of_run marking the final result caused by an input frame.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 speed_step, 1 channel_count,
// 2 start_fraction) and cfg_data; cfg_ready is high while no frame is in work.
// A frame that yields n results holds the input while the phase sequencer issues
// the n positions and then wraps up; n is at most 64. The first frame of a stream
// is only stored. After a frame is taken, each result is issued into the lane
// multiply register, then rounded and merged into the output register, one result
// per cycle while the output is not stalled. The four channel lanes share one
// phase sequencer.
// Reset clears the held frame, the phase and the output valid flag, and loads the
// register reset values. A stalled output freezes the whole lane pipeline and
// the sequencer; nothing is dropped.
module linear_interp_speed_resampler_unit
    import lirs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [SAMPLE_W-1:0]   sample_ch0,
    input  wire logic [SAMPLE_W-1:0]   sample_ch1,
    input  wire logic [SAMPLE_W-1:0]   sample_ch2,
    input  wire logic [SAMPLE_W-1:0]   sample_ch3,
    input  wire logic                  end_of_stream,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [SAMPLE_W-1:0]        out_ch0,
    output logic [SAMPLE_W-1:0]        out_ch1,
    output logic [SAMPLE_W-1:0]        out_ch2,
    output logic [SAMPLE_W-1:0]        out_ch3,
    output logic                       last_of_run,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 st_reg, st_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CCNT_W-1:0]    cc_reg, cc_next;
    logic [SFRAC_W-1:0]   sf_reg, sf_next;
    frame_t               prev_reg, prev_next;
    frame_t               cur_reg, cur_next;
    logic                 eos_reg, eos_next;
    logic                 have_reg, have_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [POS_W-1:0]     ph_reg, ph_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    frame_t               in_frame;
    frame_t               lane_res;
    frame_t               out_frame;
    logic                 in_acc;
    logic                 cfg_wr;
    logic                 en;
    logic                 issue_ok;
    logic                 issue_go;
    logic                 finish;
    logic [POS_W-1:0]     ph_sum;
    logic [POS_W-1:0]     ph_fin;
    logic [PHASE_W-1:0]   sf_phase;
    issue_t               issue;

    assign in_frame = {sample_ch3, sample_ch2, sample_ch1, sample_ch0};
    assign in_stall = (st_reg != ST_IDLE);
    assign cfg_ready = (st_reg == ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign cfg_wr   = cfg_valid && cfg_ready;
    assign sf_phase = {{(PHASE_W-SFRAC_W){1'b0}}, sf_reg};

    // phase sequencer
    assign issue_ok = (st_reg == ST_RUN) && (ph_reg < ONE_POS)
                      && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign issue_go = issue_ok && en;
    assign finish   = (st_reg == ST_RUN) && !issue_ok;
    assign ph_sum   = ph_reg + POS_W'(step_reg);
    assign ph_fin   = (ph_reg >= ONE_POS) ? (ph_reg - ONE_POS) : '0;

    assign issue.valid = issue_go;
    assign issue.last  = (ph_sum >= ONE_POS) || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign issue.frac  = ph_reg[FRAC_BITS-1:0];

    // next state
    always_comb
    begin
        st_next    = st_reg;
        step_next  = step_reg;
        cc_next    = cc_reg;
        sf_next    = sf_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        eos_next   = eos_reg;
        have_next  = have_reg;
        phase_next = phase_reg;
        ph_next    = ph_reg;
        cnt_next   = cnt_reg;

        // register writes
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_SPEED_STEP:
                begin
                    step_next = cfg_data[STEP_W-1:0];
                end
                CFG_CHANNEL_COUNT:
                begin
                    cc_next = cfg_data[CCNT_W-1:0];
                end
                CFG_START_FRACTION:
                begin
                    sf_next = cfg_data[SFRAC_W-1:0];
                    if (!have_reg)
                        phase_next = {{(PHASE_W-SFRAC_W){1'b0}}, cfg_data[SFRAC_W-1:0]};
                end
                default:
                begin
                end
            endcase
        end

        // input transaction
        if (in_acc)
        begin
            cur_next = end_of_stream ? '0 : in_frame;
            eos_next = end_of_stream;
            if (!have_reg)
            begin
                if (end_of_stream)
                begin
                    prev_next  = '0;
                    phase_next = {{(PHASE_W-SFRAC_W){1'b0}}, sf_next};
                end
                else
                begin
                    prev_next = in_frame;
                    have_next = 1'b1;
                end
            end
            else
            begin
                st_next  = ST_RUN;
                ph_next  = {1'b0, phase_reg};
                cnt_next = '0;
            end
        end

        // one output position per cycle while the pipeline is enabled
        if (issue_go)
        begin
            ph_next  = ph_sum;
            cnt_next = cnt_reg + CNT_W'(1);
        end

        // wrap-up of the frame
        if (finish)
        begin
            st_next = ST_IDLE;
            if (eos_reg)
            begin
                prev_next  = '0;
                have_next  = 1'b0;
                phase_next = sf_phase;
            end
            else
            begin
                prev_next  = cur_reg;
                phase_next = ph_fin[PHASE_W-1:0];
            end
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            step_reg  <= STEP_W'(65536);
            cc_reg    <= CCNT_W'(2);
            sf_reg    <= '0;
            prev_reg  <= '0;
            have_reg  <= 1'b0;
            phase_reg <= '0;
            eos_reg   <= 1'b0;
            ph_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            step_reg  <= step_next;
            cc_reg    <= cc_next;
            sf_reg    <= sf_next;
            prev_reg  <= prev_next;
            have_reg  <= have_next;
            phase_reg <= phase_next;
            eos_reg   <= eos_next;
            ph_reg    <= ph_next;
            cnt_reg   <= cnt_next;
        end
    end

    // current frame payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // one lane per channel
    for (genvar ch = 0; ch < MAX_CHANNELS; ch++)
    begin : g_lane
        lirs_lane u_lane (
            .clk    (clk),
            .en     (en),
            .issue  (issue),
            .use_ch (CCNT_W'(ch) < cc_reg),
            .prev_s (prev_reg[ch]),
            .cur_s  (cur_reg[ch]),
            .res    (lane_res[ch])
        );
    end

    // merge lanes into the output register
    lirs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .lane_res  (lane_res),
        .out_stall (out_stall),
        .en        (en),
        .out_valid (out_valid),
        .out_frame (out_frame),
        .out_last  (last_of_run)
    );

    assign out_ch0 = out_frame[0];
    assign out_ch1 = out_frame[1];
    assign out_ch2 = out_frame[2];
    assign out_ch3 = out_frame[3];

    // a frame after a held one starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && have_reg |=> st_reg == ST_RUN)
        else $error("held frame did not start the sequencer");

    // a first data frame is only stored
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !have_reg && !end_of_stream |=> have_reg && st_reg == ST_IDLE)
        else $error("first frame not stored");

    // result count stays within the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count beyond cap");

    // issued positions lie before the current frame
    assert property (@(posedge clk) disable iff (!rst_n)
        issue_go |-> ph_reg < ONE_POS)
        else $error("position issued past current frame");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lirs_pkg::*;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // one source frame in phase units, signed so the lane math stays signed
    localparam longint FRAME_SPAN = longint'(1) << FRAC_BITS;
    localparam longint HALF_SPAN  = FRAME_SPAN / 2;

    // one interpolated output frame as seen on the output ports
    typedef struct packed {
        frame_t ch;
        logic   last;
    } interp_result_t;

    // resampler predictor and queue of interpolated frames still to come
    class lerp_scoreboard;
        logic [STEP_W-1:0]  speed_step;
        logic [CCNT_W-1:0]  channel_count;
        logic [SFRAC_W-1:0] start_fraction;
        sample_t            held_frame [MAX_CHANNELS];
        bit                 frame_held;
        longint unsigned    phase_pos;
        interp_result_t     expected_frames [$];
        int unsigned        error_count;

        function new();
            speed_step     = STEP_W'(65536);
            channel_count  = CCNT_W'(2);
            start_fraction = '0;
            foreach (held_frame[ch])
                held_frame[ch] = '0;
            frame_held  = 1'b0;
            phase_pos   = 0;
            error_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SPEED_STEP:
                    speed_step = data[STEP_W-1:0];
                CFG_CHANNEL_COUNT:
                    channel_count = data[CCNT_W-1:0];
                CFG_START_FRACTION:
                begin
                    start_fraction = data[SFRAC_W-1:0];
                    // an idle stream picks up the new start position at once
                    if (!frame_held)
                        phase_pos = start_fraction;
                end
                default:
                    ;
            endcase
        endfunction

        // prev + frac*(cur-prev), rounded half away from zero, saturated
        function sample_t lerp_round(sample_t a, sample_t b, longint frac);
            longint acc;
            longint r;
            acc = longint'(a) * FRAME_SPAN + frac * (longint'(b) - longint'(a));
            if (acc >= 0)
                r = (acc + HALF_SPAN) >>> FRAC_BITS;
            else
                r = -((-acc + HALF_SPAN) >>> FRAC_BITS);
            if (r < -32768)
                r = -32768;
            if (r > 32767)
                r = 32767;
            return sample_t'(r);
        endfunction

        // accepted source frame: queue every output position it covers
        function void note_frame(frame_t samples, logic eos);
            sample_t         cur [MAX_CHANNELS];
            int              used;
            longint unsigned ph;
            int              n;
            interp_result_t  r;
            used = (channel_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(channel_count);
            for (int ch = 0; ch < MAX_CHANNELS; ch++)
                cur[ch] = eos ? sample_t'(0) : sample_t'(samples[ch]);

            // first frame of a stream is only stored
            if (!frame_held)
            begin
                if (eos)
                begin
                    foreach (held_frame[ch])
                        held_frame[ch] = '0;
                    phase_pos = start_fraction;
                end
                else
                begin
                    held_frame = cur;
                    frame_held = 1'b1;
                end
                return;
            end

            // walk the positions that lie before the current frame
            n  = 0;
            ph = phase_pos;
            while (ph < FRAME_SPAN && n < MAX_RESULTS)
            begin
                for (int ch = 0; ch < MAX_CHANNELS; ch++)
                    r.ch[ch] = (ch < used) ? lerp_round(held_frame[ch], cur[ch], longint'(ph))
                                           : sample_t'(0);
                r.last = (ph + speed_step >= FRAME_SPAN) || (n + 1 == MAX_RESULTS);
                expected_frames.push_back(r);
                n++;
                ph += speed_step;
            end
            ph = (ph >= FRAME_SPAN) ? ph - FRAME_SPAN : 0;

            // end of stream clears the state
            if (eos)
            begin
                foreach (held_frame[ch])
                    held_frame[ch] = '0;
                frame_held = 1'b0;
                phase_pos  = start_fraction;
            end
            else
            begin
                held_frame = cur;
                phase_pos  = ph & 64'hFFFF_FFFF;
            end
        endfunction

        function void check_result(interp_result_t got);
            interp_result_t want;
            if (expected_frames.size() == 0)
            begin
                $display("%0t: output transaction with none expected, actual %h", $time, got);
                error_count++;
                return;
            end
            want = expected_frames.pop_front();
            for (int ch = 0; ch < MAX_CHANNELS; ch++)
            begin
                if (got.ch[ch] !== want.ch[ch])
                begin
                    $display("%0t: out_ch%0d mismatch, expected %h, actual %h",
                             $time, ch, want.ch[ch], got.ch[ch]);
                    error_count++;
                end
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last_of_run mismatch, expected %b, actual %b",
                         $time, want.last, got.last);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    frame_t                in_frame = '0;
    logic                  in_eos = 1'b0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire logic             in_stall;
    wire logic             out_valid;
    wire logic             cfg_ready;
    wire logic [SAMPLE_W-1:0] out_ch0;
    wire logic [SAMPLE_W-1:0] out_ch1;
    wire logic [SAMPLE_W-1:0] out_ch2;
    wire logic [SAMPLE_W-1:0] out_ch3;
    wire logic             last_of_run;
    interp_result_t        seen_result;
    bit                    hold_request = 1'b0;

    lerp_scoreboard sb = new();

    assign seen_result = {out_ch3, out_ch2, out_ch1, out_ch0, last_of_run};

    linear_interp_speed_resampler_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_ch0    (in_frame[0]),
        .sample_ch1    (in_frame[1]),
        .sample_ch2    (in_frame[2]),
        .sample_ch3    (in_frame[3]),
        .end_of_stream (in_eos),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_ch0       (out_ch0),
        .out_ch1       (out_ch1),
        .out_ch2       (out_ch2),
        .out_ch3       (out_ch3),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // idle stretch length, mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        else if (r < 90)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic frame_t mk_frame(int s0, int s1, int s2, int s3);
        return {SAMPLE_W'(s3), SAMPLE_W'(s2), SAMPLE_W'(s1), SAMPLE_W'(s0)};
    endfunction

    // one input transaction, then a random gap
    task automatic send_frame(input frame_t f, input logic eos);
        int gap;
        gap = ($urandom_range(0, 1) == 0) ? 0 : idle_len();
        in_valid <= 1'b1;
        in_frame <= f;
        in_eos   <= eos;
        do
            @(posedge clk);
        while (in_stall);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one configuration transaction, then cfg_valid is dropped and the bus idles
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering input, drain all expected frames, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // monitor: accepted inputs, register writes and outputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_frame(in_frame, in_eos);
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                sb.check_result(seen_result);
        end
    end

    // output stall pattern, with one long hold-off
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            if (hold_request && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("tb_top failed");
        $finish;
    end

    // stimulus
    initial
    begin
        frame_t      f;
        logic        eos;
        int unsigned step;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: end with nothing held, extremes, tail into zero
        send_frame(mk_frame(0, 0, 0, 0), 1'b1);
        send_frame(mk_frame(32767, 32767, 32767, 32767), 1'b0);
        send_frame(mk_frame(-32768, -32768, -32768, -32768), 1'b0);
        send_frame(mk_frame(16'h1234, -1, 0, 16'h5555), 1'b0);
        send_frame(mk_frame(77, -77, 1, -1), 1'b1);
        send_frame(mk_frame(5, 6, 7, 8), 1'b1);

        // half steps from a half start: rounding of exact halves
        wait_idle();
        program_reg(CFG_SPEED_STEP, 32768);
        program_reg(CFG_CHANNEL_COUNT, 4);
        program_reg(CFG_START_FRACTION, 16'h8000);
        send_frame(mk_frame(32767, -32768, 1, -1), 1'b0);
        send_frame(mk_frame(-32768, 32767, -1, 1), 1'b0);
        send_frame(mk_frame(0, 0, 32767, -32768), 1'b0);
        send_frame(mk_frame(0, 0, 0, 0), 1'b1);

        // zero step hits the result cap, channel count above the maximum
        wait_idle();
        program_reg(CFG_SPEED_STEP, 0);
        program_reg(CFG_CHANNEL_COUNT, 7);
        program_reg(CFG_START_FRACTION, 0);
        send_frame(mk_frame(1, 2, 3, 4), 1'b0);
        send_frame(mk_frame(-1, -2, -3, -4), 1'b0);
        send_frame(mk_frame(9, 9, 9, 9), 1'b1);

        // largest step skips frames, zero channels in use
        wait_idle();
        program_reg(CFG_SPEED_STEP, 20'hFFFFF);
        program_reg(CFG_CHANNEL_COUNT, 0);
        program_reg(CFG_START_FRACTION, 65535);
        send_frame(mk_frame(100, 200, 300, 400), 1'b0);
        send_frame(mk_frame(-100, -200, -300, -400), 1'b0);
        send_frame(mk_frame(1, 1, 1, 1), 1'b0);
        send_frame(mk_frame(2, 2, 2, 2), 1'b0);
        send_frame(mk_frame(3, 3, 3, 3), 1'b0);
        send_frame(mk_frame(4, 4, 4, 4), 1'b1);

        // write to the unused index, then slowest normal speed on one channel
        wait_idle();
        program_reg(CFG_UNUSED_INDEX, $urandom & 20'hFFFFF);
        program_reg(CFG_SPEED_STEP, 1024);
        program_reg(CFG_CHANNEL_COUNT, 1);
        program_reg(CFG_START_FRACTION, 1);
        send_frame(mk_frame(-30000, 5, 6, 7), 1'b0);
        send_frame(mk_frame(30000, 8, 9, 10), 1'b0);

        // start fraction written while a frame is held waits for end of stream
        wait_idle();
        program_reg(CFG_START_FRACTION, 16'h4000);
        send_frame(mk_frame(0, 0, 0, 0), 1'b1);
        send_frame(mk_frame(12345, 0, 0, 0), 1'b0);
        send_frame(mk_frame(-12345, 0, 0, 0), 1'b0);
        send_frame(mk_frame(0, 0, 0, 0), 1'b1);

        // random phases: streams of random frames under random settings
        for (int p = 0; p < 9; p++)
        begin
            wait_idle();
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0: step = 1024;
                    1: step = 524288;
                    2: step = $urandom_range(1024, 8192);
                    3: step = $urandom_range(8192, 32768);
                    4, 5, 6: step = $urandom_range(32768, 131072);
                    7: step = $urandom_range(131072, 524288);
                    8: step = $urandom & 20'hFFFFF;
                    default: step = 65536;
                endcase
                program_reg(CFG_SPEED_STEP, step);
            end
            if ($urandom_range(0, 3) != 0)
                program_reg(CFG_CHANNEL_COUNT, ($urandom_range(0, 5) != 0) ?
                            $urandom_range(1, 4) : $urandom_range(0, 7));
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: program_reg(CFG_START_FRACTION, 0);
                    1: program_reg(CFG_START_FRACTION, 65535);
                    default: program_reg(CFG_START_FRACTION, $urandom_range(0, 65535));
                endcase
            end

            // the long output hold-off lands during this traffic
            if (p == 0)
                hold_request = 1'b1;

            for (int k = 0; k < 32; k++)
            begin
                eos = ($urandom_range(0, 99) < 7);
                for (int c = 0; c < MAX_CHANNELS; c++)
                begin
                    case ($urandom_range(0, 9))
                        0: f[c] = 16'h7FFF;
                        1: f[c] = 16'h8000;
                        2: f[c] = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
                        default: f[c] = SAMPLE_W'($urandom);
                    endcase
                end
                send_frame(f, eos);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // drain and finish
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
